// ===== design/sclc_pkg.sv =====
package sclc_pkg;

    // Operating phases, also shown on the phase output
    typedef enum logic [2:0] {
        PH_DIGIT1 = 3'd0,
        PH_GAP1   = 3'd1,
        PH_DIGIT2 = 3'd2,
        PH_GAP2   = 3'd3,
        PH_UNLOCK = 3'd4,
        PH_REJECT = 3'd5,
        PH_WAIT   = 3'd6,
        PH_EMERG  = 3'd7
    } phase_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_SECRET_FIRST  = 3'd0;
    localparam logic [2:0] CFG_SECRET_SECOND = 3'd1;
    localparam logic [2:0] CFG_IDLE_LIMIT    = 3'd2;
    localparam logic [2:0] CFG_EDGE_HOLDOFF  = 3'd3;
    localparam logic [2:0] CFG_DIGIT_GAP     = 3'd4;
    localparam logic [2:0] CFG_RELAY_TIME    = 3'd5;
    localparam logic [2:0] CFG_BEEP_HALF     = 3'd6;
    localparam logic [2:0] CFG_RESULT_WAIT   = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // Defaults for the top level parameters
    localparam int DEF_COUNT_LIMIT  = 9;
    localparam int DEF_REJECT_BEEPS = 6;

    // Emergency melody: two parts of fixed beeps
    localparam logic [6:0] MELODY_TWICE_A = 7'd4;
    localparam logic [3:0] MELODY_BEEPS_A = 4'd8;
    localparam logic [6:0] MELODY_TWICE_B = 7'd10;
    localparam logic [3:0] MELODY_BEEPS_B = 4'd4;
    localparam logic [5:0] MELODY_HALF_A  = 6'd2;
    localparam logic [5:0] MELODY_HALF_B  = 6'd5;

    typedef struct packed {
        logic [3:0] secret_first;
        logic [3:0] secret_second;
        logic [7:0] idle_limit;
        logic [3:0] edge_holdoff;
        logic [7:0] digit_gap;
        logic [9:0] relay_time;
        logic [5:0] beep_half;
        logic [7:0] result_wait;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        secret_first:  4'd3,
        secret_second: 4'd2,
        idle_limit:    8'd30,
        edge_holdoff:  4'd2,
        digit_gap:     8'd10,
        relay_time:    10'd100,
        beep_half:     6'd4,
        result_wait:   8'd20
    };

    typedef struct packed {
        phase_t     phase;
        logic [3:0] swipe_count;
        logic [3:0] first_digit;
        logic       previous_level;
        logic [7:0] idle_ticks;
        logic [9:0] phase_timer;
        logic [3:0] beep_counter;
        logic       melody_part;
        logic       emergency_prev;
        logic [3:0] display_digit;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:          PH_DIGIT1,
        swipe_count:    4'd0,
        first_digit:    4'd0,
        previous_level: 1'b1,
        idle_ticks:     8'd0,
        phase_timer:    10'd0,
        beep_counter:   4'd0,
        melody_part:    1'b0,
        emergency_prev: 1'b0,
        display_digit:  4'd0
    };

    typedef struct packed {
        logic [6:0] segments;
        logic       relay_on;
        logic       buzzer_on;
        logic [2:0] phase;
    } result_t;

    // Digit to 7-segment pattern, blank above 9
    function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
        logic [6:0] pat;
        unique case (digit)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h6F;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

// ===== design/swipe_code_lock_controller.sv =====
// Swipe code lock controller. One input item per sample tick carries the two
// light sensor levels and the emergency line; each item yields one result item
// with the display pattern, relay and buzzer drives and the current phase.
// An item is taken every clock cycle: the tick's state update is a single pass
// of counters and compares between the state registers and the output
// register, and in_ready drops only while a result waits in the output register
// and out_ready is low. Configuration is written through cfg_we/cfg_index/
// cfg_data and takes effect on the next item; write only while idle.
module swipe_code_lock_controller #(
    parameter int COUNT_LIMIT  = sclc_pkg::DEF_COUNT_LIMIT,
    parameter int REJECT_BEEPS = sclc_pkg::DEF_REJECT_BEEPS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             sensor_one,
    input  logic                             sensor_two,
    input  logic                             emergency_line,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [6:0]                       segments,
    output logic                             relay_on,
    output logic                             buzzer_on,
    output logic [2:0]                       phase,
    input  logic                             cfg_we,
    input  logic [sclc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sclc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sclc_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t result_reg;
    logic    out_valid_reg;
    logic    accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SECRET_FIRST:  cfg_reg.secret_first  <= cfg_data[3:0];
                CFG_SECRET_SECOND: cfg_reg.secret_second <= cfg_data[3:0];
                CFG_IDLE_LIMIT:    cfg_reg.idle_limit    <= cfg_data[7:0];
                CFG_EDGE_HOLDOFF:  cfg_reg.edge_holdoff  <= cfg_data[3:0];
                CFG_DIGIT_GAP:     cfg_reg.digit_gap     <= cfg_data[7:0];
                CFG_RELAY_TIME:    cfg_reg.relay_time    <= cfg_data[9:0];
                CFG_BEEP_HALF:     cfg_reg.beep_half     <= cfg_data[5:0];
                CFG_RESULT_WAIT:   cfg_reg.result_wait   <= cfg_data[7:0];
            endcase
        end
    end

    sclc_step #(
        .COUNT_LIMIT  (COUNT_LIMIT),
        .REJECT_BEEPS (REJECT_BEEPS)
    ) u_step (
        .state          (state_reg),
        .cfg            (cfg_reg),
        .sensor_one     (sensor_one),
        .sensor_two     (sensor_two),
        .emergency_line (emergency_line),
        .state_next     (state_next),
        .result         (result_next)
    );

    // Controller state, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= STATE_RESET;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign segments  = result_reg.segments;
    assign relay_on  = result_reg.relay_on;
    assign buzzer_on = result_reg.buzzer_on;
    assign phase     = result_reg.phase;

endmodule

// ===== design/sclc_step.sv =====
module sclc_step #(
    parameter int COUNT_LIMIT  = sclc_pkg::DEF_COUNT_LIMIT,
    parameter int REJECT_BEEPS = sclc_pkg::DEF_REJECT_BEEPS
) (
    input  sclc_pkg::state_t  state,
    input  sclc_pkg::cfg_t    cfg,
    input  logic              sensor_one,
    input  logic              sensor_two,
    input  logic              emergency_line,
    output sclc_pkg::state_t  state_next,
    output sclc_pkg::result_t result
);
    import sclc_pkg::*;

    localparam logic [3:0] LIMIT = 4'(COUNT_LIMIT);
    localparam logic [3:0] BEEPS = 4'(REJECT_BEEPS);

    typedef struct packed {
        logic [9:0] timer;
        logic [3:0] count;
        logic       done;
    } beep_step_t;

    typedef struct packed {
        state_t st;
        logic   done;
    } entry_step_t;

    // One tick of a beep sequence; twice_half is the full beep period
    function automatic beep_step_t beep_tick(input logic [9:0] timer,
                                             input logic [3:0] count,
                                             input logic [6:0] twice_half,
                                             input logic [3:0] beeps);
        beep_step_t r;
        r.timer = timer + 10'd1;
        r.count = count;
        r.done  = 1'b0;
        if (r.timer >= {3'd0, twice_half}) begin
            r.timer = 10'd0;
            r.count = count + 4'd1;
            if (r.count >= beeps) begin
                r.count = 4'd0;
                r.done  = 1'b1;
            end
        end
        return r;
    endfunction

    // One tick of digit entry on the given sensor level
    function automatic entry_step_t entry_tick(input state_t s, input logic level,
                                               input cfg_t c);
        entry_step_t r;
        r.st   = s;
        r.done = 1'b0;
        if (s.phase_timer != 10'd0) begin
            // holdoff: follow the level only
            r.st.phase_timer    = s.phase_timer - 10'd1;
            r.st.previous_level = level;
        end else begin
            if (!level && s.previous_level) begin
                r.st.swipe_count   = (s.swipe_count < LIMIT) ? s.swipe_count + 4'd1 : LIMIT;
                r.st.display_digit = r.st.swipe_count;
                r.st.idle_ticks    = 8'd0;
                r.st.phase_timer   = {6'd0, c.edge_holdoff};
            end
            r.st.previous_level = level;
            if (r.st.idle_ticks != 8'hFF)
                r.st.idle_ticks = r.st.idle_ticks + 8'd1;
            r.done = (r.st.swipe_count != 4'd0) && (r.st.idle_ticks >= c.idle_limit);
        end
        return r;
    endfunction

    // Next state
    always_comb
    begin
        entry_step_t ent;
        beep_step_t  bp;
        logic        rise;
        rise = emergency_line && !state.emergency_prev;
        state_next = state;
        state_next.emergency_prev = emergency_line;
        ent = '0;
        bp  = '0;
        if (rise) begin
            state_next.phase        = PH_EMERG;
            state_next.melody_part  = 1'b0;
            state_next.beep_counter = 4'd0;
            state_next.phase_timer  = 10'd0;
            state_next.swipe_count  = 4'd0;
            state_next.idle_ticks   = 8'd0;
        end else begin
            unique case (state.phase)
                PH_DIGIT1:
                begin
                    ent = entry_tick(state, sensor_one, cfg);
                    state_next = ent.st;
                    state_next.emergency_prev = emergency_line;
                    if (ent.done) begin
                        state_next.first_digit = ent.st.swipe_count;
                        state_next.phase       = PH_GAP1;
                        state_next.phase_timer = {2'd0, cfg.digit_gap};
                    end
                end
                PH_GAP1:
                begin
                    if (state.phase_timer <= 10'd1) begin
                        state_next.phase          = PH_DIGIT2;
                        state_next.swipe_count    = 4'd0;
                        state_next.idle_ticks     = 8'd0;
                        state_next.phase_timer    = 10'd0;
                        state_next.previous_level = sensor_two;
                    end else begin
                        state_next.phase_timer = state.phase_timer - 10'd1;
                    end
                end
                PH_DIGIT2:
                begin
                    ent = entry_tick(state, sensor_two, cfg);
                    state_next = ent.st;
                    state_next.emergency_prev = emergency_line;
                    if (ent.done) begin
                        state_next.phase       = PH_GAP2;
                        state_next.phase_timer = {2'd0, cfg.digit_gap};
                    end
                end
                PH_GAP2:
                begin
                    if (state.phase_timer <= 10'd1) begin
                        if (state.first_digit == cfg.secret_first &&
                            state.swipe_count == cfg.secret_second) begin
                            state_next.phase       = PH_UNLOCK;
                            state_next.phase_timer = cfg.relay_time;
                        end else begin
                            state_next.phase        = PH_REJECT;
                            state_next.phase_timer  = 10'd0;
                            state_next.beep_counter = 4'd0;
                        end
                    end else begin
                        state_next.phase_timer = state.phase_timer - 10'd1;
                    end
                end
                PH_UNLOCK:
                begin
                    if (state.phase_timer <= 10'd1) begin
                        state_next.phase       = PH_WAIT;
                        state_next.phase_timer = {2'd0, cfg.result_wait};
                    end else begin
                        state_next.phase_timer = state.phase_timer - 10'd1;
                    end
                end
                PH_REJECT:
                begin
                    bp = beep_tick(state.phase_timer, state.beep_counter,
                                   {cfg.beep_half, 1'b0}, BEEPS);
                    state_next.phase_timer  = bp.timer;
                    state_next.beep_counter = bp.count;
                    if (bp.done) begin
                        state_next.phase       = PH_WAIT;
                        state_next.phase_timer = {2'd0, cfg.result_wait};
                    end
                end
                PH_WAIT:
                begin
                    if (state.phase_timer <= 10'd1) begin
                        state_next.phase          = PH_DIGIT1;
                        state_next.swipe_count    = 4'd0;
                        state_next.idle_ticks     = 8'd0;
                        state_next.phase_timer    = 10'd0;
                        state_next.display_digit  = 4'd0;
                        state_next.previous_level = sensor_one;
                    end else begin
                        state_next.phase_timer = state.phase_timer - 10'd1;
                    end
                end
                PH_EMERG:
                begin
                    if (!state.melody_part)
                        bp = beep_tick(state.phase_timer, state.beep_counter,
                                       MELODY_TWICE_A, MELODY_BEEPS_A);
                    else
                        bp = beep_tick(state.phase_timer, state.beep_counter,
                                       MELODY_TWICE_B, MELODY_BEEPS_B);
                    state_next.phase_timer  = bp.timer;
                    state_next.beep_counter = bp.count;
                    if (bp.done) begin
                        if (!state.melody_part) begin
                            state_next.melody_part = 1'b1;
                        end else begin
                            // melody over: restart entry, display cleared
                            state_next.melody_part    = 1'b0;
                            state_next.phase          = PH_DIGIT1;
                            state_next.swipe_count    = 4'd0;
                            state_next.idle_ticks     = 8'd0;
                            state_next.phase_timer    = 10'd0;
                            state_next.display_digit  = 4'd0;
                            state_next.previous_level = sensor_one;
                        end
                    end
                end
            endcase
        end
    end

    // Result from the updated state
    always_comb
    begin
        logic [5:0] half;
        half = 6'd0;
        unique case (state_next.phase)
            PH_REJECT: half = cfg.beep_half;
            PH_EMERG:  half = state_next.melody_part ? MELODY_HALF_B : MELODY_HALF_A;
            default:   half = 6'd0;
        endcase
        result.segments  = seg_pattern(state_next.display_digit);
        result.relay_on  = (state_next.phase == PH_UNLOCK);
        result.buzzer_on = (state_next.phase_timer < {4'd0, half});
        result.phase     = state_next.phase;
    end

endmodule

// ===== design/sclc_checker.sv =====
module sclc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] segments,
    input logic       relay_on,
    input logic       buzzer_on,
    input logic [2:0] phase
);
    import sclc_pkg::*;

    // Relay drives only while unlocked
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && relay_on |-> phase == PH_UNLOCK)
        else $error("relay on outside unlock phase");

    // Buzzer sounds only in reject or emergency
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && buzzer_on |-> phase == PH_REJECT || phase == PH_EMERG)
        else $error("buzzer on outside a beep phase");

    // An empty output register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(segments) &&
        $stable(relay_on) && $stable(buzzer_on) && $stable(phase))
        else $error("stalled result changed");

endmodule

bind swipe_code_lock_controller sclc_checker u_sclc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .segments  (segments),
    .relay_on  (relay_on),
    .buzzer_on (buzzer_on),
    .phase     (phase)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import sclc_pkg::*;

    // Segment patterns for digits 0..9, digit 0 in the low bits
    localparam logic [69:0] GLYPHS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                      7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};
    localparam int COUNT_MAX   = DEF_COUNT_LIMIT;
    localparam int REJECT_MAX  = DEF_REJECT_BEEPS;
    localparam int HOLD_CYCLES = 200;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   sensor_one;
    logic                   sensor_two;
    logic                   emergency_line;
    logic                   out_valid;
    logic                   out_ready;
    logic [6:0]             segments;
    logic                   relay_on;
    logic                   buzzer_on;
    logic [2:0]             phase;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    swipe_code_lock_controller dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sensor_one     (sensor_one),
        .sensor_two     (sensor_two),
        .emergency_line (emergency_line),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .segments       (segments),
        .relay_on       (relay_on),
        .buzzer_on      (buzzer_on),
        .phase          (phase),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Lock state as the testbench expects it
    cfg_t       lock_cfg;
    phase_t     exp_phase;
    logic [3:0] exp_count;
    logic [3:0] exp_first;
    logic [3:0] exp_beeps;
    logic [3:0] exp_shown;
    logic       exp_level;
    logic       exp_part;
    logic       exp_em_prev;
    logic [7:0] exp_idle;
    logic [9:0] exp_timer;

    result_t    expected_q[$];
    result_t    want;
    int         fail_count;
    int         items_sent;
    bit         gaps_on;
    bit         stalls_on;
    int         hold_left;
    int         stall_left;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Lock behavior
    // ---------------------------------------------------------------

    // Fresh digit entry, level sampled from the sensor of the new digit
    function automatic void begin_entry(input logic lvl);
        exp_phase = PH_DIGIT1;
        exp_count = 4'd0;
        exp_idle  = 8'd0;
        exp_timer = 10'd0;
        exp_shown = 4'd0;
        exp_level = lvl;
    endfunction

    function automatic void lock_reset();
        lock_cfg.secret_first  = 4'd3;
        lock_cfg.secret_second = 4'd2;
        lock_cfg.idle_limit    = 8'd30;
        lock_cfg.edge_holdoff  = 4'd2;
        lock_cfg.digit_gap     = 8'd10;
        lock_cfg.relay_time    = 10'd100;
        lock_cfg.beep_half     = 6'd4;
        lock_cfg.result_wait   = 8'd20;
        exp_first   = 4'd0;
        exp_beeps   = 4'd0;
        exp_part    = 1'b0;
        exp_em_prev = 1'b0;
        begin_entry(1'b1);
    endfunction

    // Timed phase countdown; true on the last tick
    function automatic bit countdown_done();
        if (exp_timer <= 10'd1)
        begin
            exp_timer = 10'd0;
            return 1'b1;
        end
        exp_timer = exp_timer - 10'd1;
        return 1'b0;
    endfunction

    // One tick of a beep train; true once all beeps are played
    function automatic bit beep_step(input int half, input int beeps);
        exp_timer = exp_timer + 10'd1;
        if (exp_timer >= 2 * half)
        begin
            exp_timer = 10'd0;
            exp_beeps = exp_beeps + 4'd1;
            if (exp_beeps >= beeps)
            begin
                exp_beeps = 4'd0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // One tick of swipe counting; true when the digit is complete
    function automatic bit swipe_step(input logic lvl);
        if (exp_timer != 10'd0)
        begin
            // holdoff: follow the level only
            exp_timer = exp_timer - 10'd1;
            exp_level = lvl;
            return 1'b0;
        end
        if (!lvl && exp_level)
        begin
            if (exp_count < COUNT_MAX)
                exp_count = exp_count + 4'd1;
            else
                exp_count = 4'(COUNT_MAX);
            exp_shown = exp_count;
            exp_idle  = 8'd0;
            exp_timer = {6'd0, lock_cfg.edge_holdoff};
        end
        exp_level = lvl;
        if (exp_idle < 8'd255)
            exp_idle = exp_idle + 8'd1;
        return (exp_count > 4'd0) && (exp_idle >= lock_cfg.idle_limit);
    endfunction

    // Advance the lock by one accepted item and give the result it causes
    function automatic result_t lock_expect(input logic s1, input logic s2, input logic em);
        result_t r;
        logic    rise;
        int      half;
        bit      buzz;
        rise = em && !exp_em_prev;
        half = 0;
        buzz = 1'b0;
        exp_em_prev = em;

        if (rise)
        begin
            exp_phase = PH_EMERG;
            exp_part  = 1'b0;
            exp_beeps = 4'd0;
            exp_timer = 10'd0;
            exp_count = 4'd0;
            exp_idle  = 8'd0;
        end
        else
        begin
            case (exp_phase)
                PH_DIGIT1:
                    if (swipe_step(s1))
                    begin
                        exp_first = exp_count;
                        exp_phase = PH_GAP1;
                        exp_timer = {2'd0, lock_cfg.digit_gap};
                    end
                PH_GAP1:
                    if (countdown_done())
                    begin
                        exp_phase = PH_DIGIT2;
                        exp_count = 4'd0;
                        exp_idle  = 8'd0;
                        exp_timer = 10'd0;
                        exp_level = s2;
                    end
                PH_DIGIT2:
                    if (swipe_step(s2))
                    begin
                        exp_phase = PH_GAP2;
                        exp_timer = {2'd0, lock_cfg.digit_gap};
                    end
                PH_GAP2:
                    if (countdown_done())
                    begin
                        if (exp_first == lock_cfg.secret_first &&
                            exp_count == lock_cfg.secret_second)
                        begin
                            exp_phase = PH_UNLOCK;
                            exp_timer = lock_cfg.relay_time;
                        end
                        else
                        begin
                            exp_phase = PH_REJECT;
                            exp_timer = 10'd0;
                            exp_beeps = 4'd0;
                        end
                    end
                PH_UNLOCK:
                    if (countdown_done())
                    begin
                        exp_phase = PH_WAIT;
                        exp_timer = {2'd0, lock_cfg.result_wait};
                    end
                PH_REJECT:
                    if (beep_step(int'(lock_cfg.beep_half), REJECT_MAX))
                    begin
                        exp_phase = PH_WAIT;
                        exp_timer = {2'd0, lock_cfg.result_wait};
                    end
                PH_WAIT:
                    if (countdown_done())
                        begin_entry(s1);
                default:
                    // emergency melody, two parts
                    if (!exp_part)
                    begin
                        if (beep_step(int'(MELODY_HALF_A), int'(MELODY_BEEPS_A)))
                            exp_part = 1'b1;
                    end
                    else if (beep_step(int'(MELODY_HALF_B), int'(MELODY_BEEPS_B)))
                    begin
                        exp_part = 1'b0;
                        begin_entry(s1);
                    end
            endcase
        end

        if (exp_phase == PH_REJECT)
        begin
            half = int'(lock_cfg.beep_half);
            buzz = 1'b1;
        end
        else if (exp_phase == PH_EMERG)
        begin
            half = exp_part ? int'(MELODY_HALF_B) : int'(MELODY_HALF_A);
            buzz = 1'b1;
        end

        r.segments  = (exp_shown <= 4'd9) ? GLYPHS[exp_shown * 7 +: 7] : 7'h00;
        r.relay_on  = (exp_phase == PH_UNLOCK);
        r.buzzer_on = buzz && (exp_timer < half);
        r.phase     = exp_phase;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Prediction on accepted items, checking of result items
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_q.push_back(lock_expect(sensor_one, sensor_two, emergency_line));
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result item with no expected item waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (segments !== want.segments)
                    begin
                        $error("segments: expected %h, got %h", want.segments, segments);
                        fail_count++;
                    end
                    if (relay_on !== want.relay_on)
                    begin
                        $error("relay_on: expected %b, got %b", want.relay_on, relay_on);
                        fail_count++;
                    end
                    if (buzzer_on !== want.buzzer_on)
                    begin
                        $error("buzzer_on: expected %b, got %b", want.buzzer_on, buzzer_on);
                        fail_count++;
                    end
                    if (phase !== want.phase)
                    begin
                        $error("phase: expected %0d, got %0d", want.phase, phase);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Result side: random stall bursts, plus a long hold-off on request
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    // Offer one item and return at the edge that accepts it
    task automatic send_tick(input logic s1, input logic s2, input logic em);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        sensor_one     <= s1;
        sensor_two     <= s2;
        emergency_line <= em;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Stop offering and wait for every expected result item
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Write all registers while the lock is idle
    task automatic load_settings(input cfg_t c);
        settle();
        put_reg(CFG_SECRET_FIRST, 10'(c.secret_first));
        put_reg(CFG_SECRET_SECOND, 10'(c.secret_second));
        put_reg(CFG_IDLE_LIMIT, 10'(c.idle_limit));
        put_reg(CFG_EDGE_HOLDOFF, 10'(c.edge_holdoff));
        put_reg(CFG_DIGIT_GAP, 10'(c.digit_gap));
        put_reg(CFG_RELAY_TIME, c.relay_time);
        put_reg(CFG_BEEP_HALF, 10'(c.beep_half));
        put_reg(CFG_RESULT_WAIT, 10'(c.result_wait));
        cfg_we   <= 1'b0;
        lock_cfg = c;
    endtask

    task automatic quiet_ticks(input int n);
        repeat (n) send_tick(1'b1, 1'b1, 1'b0);
    endtask

    // Swipes on one sensor: a high lead-in past the holdoff, then a low dip
    task automatic swipe_run(input int swipes, input bit on_two);
        int lead;
        int dip;
        for (int k = 0; k < swipes; k++)
        begin
            lead = lock_cfg.edge_holdoff + $urandom_range(1, 2);
            dip  = $urandom_range(1, 2);
            repeat (lead)
                if (on_two)
                    send_tick(1'($urandom_range(0, 1)), 1'b1, 1'b0);
                else
                    send_tick(1'b1, 1'($urandom_range(0, 1)), 1'b0);
            repeat (dip)
                if (on_two)
                    send_tick(1'($urandom_range(0, 1)), 1'b0, 1'b0);
                else
                    send_tick(1'b0, 1'b1, 1'b0);
        end
    endtask

    // Full code entry, then enough quiet ticks to see the verdict through
    task automatic code_attempt(input int first_swipes, input int second_swipes);
        int digit_end;
        int reject_len;
        int verdict_len;
        digit_end   = lock_cfg.edge_holdoff + lock_cfg.idle_limit + 2 +
                      ((lock_cfg.digit_gap == 0) ? 1 : lock_cfg.digit_gap);
        reject_len  = REJECT_MAX * ((lock_cfg.beep_half == 0) ? 1 : 2 * lock_cfg.beep_half);
        verdict_len = (lock_cfg.relay_time > reject_len) ? lock_cfg.relay_time : reject_len;
        if (verdict_len == 0)
            verdict_len = 1;
        swipe_run(first_swipes, 1'b0);
        quiet_ticks(digit_end);
        swipe_run(second_swipes, 1'b1);
        quiet_ticks(digit_end + verdict_len + lock_cfg.result_wait + 3);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Every input combination, twice, at reset settings
    task automatic test_input_corners();
        logic [2:0] v;
        for (int k = 0; k < 16; k++)
        begin
            v = k[2:0];
            send_tick(v[0], v[1], v[2]);
        end
    endtask

    // Abort, hold the line high, then a second rise restarts the melody
    task automatic test_emergency_melody();
        send_tick(1'b1, 1'b1, 1'b1);
        repeat (20) send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b0);
        quiet_ticks(75);
    endtask

    // Reset secrets and timings, right code opens the relay
    task automatic test_default_unlock();
        code_attempt(3, 2);
    endtask

    // All registers at zero, then a reachable secret with zero timings
    task automatic test_minimum_settings();
        cfg_t c;
        c = '0;
        load_settings(c);
        code_attempt(1, 1);
        code_attempt(2, 3);
        c.secret_first  = 4'd1;
        c.secret_second = 4'd1;
        load_settings(c);
        code_attempt(1, 1);
    endtask

    // All registers at their top value; long phases cut short by an abort
    task automatic test_maximum_settings();
        cfg_t c;
        c = '1;
        load_settings(c);
        swipe_run(2, 1'b0);
        quiet_ticks(20);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b0);
        quiet_ticks(75);
    endtask

    // Result side holds off while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        hold_left = HOLD_CYCLES;
        repeat (40) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
    endtask

    // Random settings, mostly well-formed codes, some noise and aborts
    task automatic test_random_codes(input int stop_at);
        cfg_t c;
        int   pick;
        while (items_sent < stop_at)
        begin
            c.secret_first  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                          : 4'($urandom_range(0, 9));
            c.secret_second = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                          : 4'($urandom_range(0, 9));
            c.idle_limit    = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 4))
                                                          : 8'($urandom_range(5, 8));
            c.edge_holdoff  = 4'($urandom_range(0, 3));
            c.digit_gap     = 8'($urandom_range(0, 4));
            c.relay_time    = 10'($urandom_range(0, 8));
            c.beep_half     = 6'($urandom_range(0, 3));
            c.result_wait   = 8'($urandom_range(0, 5));
            load_settings(c);
            for (int a = 0; a < 3 && items_sent < stop_at; a++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    code_attempt(int'(c.secret_first), int'(c.secret_second));
                else if (pick < 7)
                    code_attempt($urandom_range(1, 5), $urandom_range(0, 5));
                else if (pick == 7)
                    code_attempt($urandom_range(9, 11), $urandom_range(1, 11));
                else if (pick == 8)
                    repeat ($urandom_range(8, 30))
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  $urandom_range(0, 9) == 0);
                else
                begin
                    // entry broken off by an abort
                    swipe_run($urandom_range(1, 4), 1'b0);
                    send_tick(1'b1, 1'b1, 1'b1);
                    send_tick(1'b1, 1'b1, 1'b0);
                    quiet_ticks(74);
                end
            end
        end
    endtask

    // Last stretch with no gaps and no stalls
    task automatic test_steady_stream(input int stop_at);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_random_codes(stop_at);
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sensor_one     = 1'b0;
        sensor_two     = 1'b0;
        emergency_line = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        fail_count     = 0;
        items_sent     = 0;
        gaps_on        = 1'b1;
        stalls_on      = 1'b1;
        hold_left      = 0;
        lock_reset();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_input_corners();
        test_emergency_melody();
        test_default_unlock();
        test_minimum_settings();
        test_maximum_settings();
        test_output_backpressure();
        test_random_codes(1000);
        test_steady_stream(1150);

        settle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
